FILE: design/drmt_pkg.sv
// Shared constants, command and outcome codes, and controller/datapath interface types.
package drmt_pkg;

    localparam int MAX_ENTRIES_DEF = 512;
    localparam int COORD_BITS_DEF  = 16;

    localparam int COORD_W   = 16;
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 9;
    localparam int OUTCOME_W = 3;
    localparam int SLOT_W    = 9;
    localparam int COUNT_W   = 10;
    localparam int KIND_W    = 3;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [OUTCOME_W-1:0] OC_APPENDED = 3'd0;
    localparam logic [OUTCOME_W-1:0] OC_MERGED   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OC_DROPPED  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OC_READ_OK  = 3'd3;
    localparam logic [OUTCOME_W-1:0] OC_READ_OOR = 3'd4;
    localparam logic [OUTCOME_W-1:0] OC_CLEARED  = 3'd5;

    // Kinds of result that the controller asks the datapath to stage.
    localparam logic [KIND_W-1:0] K_APPEND   = 3'd0;
    localparam logic [KIND_W-1:0] K_MERGE    = 3'd1;
    localparam logic [KIND_W-1:0] K_DROP     = 3'd2;
    localparam logic [KIND_W-1:0] K_READ_OK  = 3'd3;
    localparam logic [KIND_W-1:0] K_READ_OOR = 3'd4;
    localparam logic [KIND_W-1:0] K_CLEAR    = 3'd5;
    localparam logic [KIND_W-1:0] K_BAD_CMD  = 3'd6;

    typedef struct packed {
        logic              load;
        logic              scan_start;
        logic              scan_issue;
        logic              read_issue;
        logic              stage;
        logic [KIND_W-1:0] kind;
        logic              emit;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             in_range;
        logic             scan_more;
        logic             pending;
        logic             hit;
    } stat_t;

endpackage

FILE: design/drmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module drmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/drmt_datapath.sv
// Datapath: request registers, rectangle store, scan compare and merge, result registers.
module drmt_datapath #(
    parameter int MAX_ENTRIES = drmt_pkg::MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = drmt_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  drmt_pkg::ctl_t                       ctl,
    output drmt_pkg::stat_t                      stat,
    input  logic [drmt_pkg::CMD_W-1:0]           command,
    input  logic signed [drmt_pkg::COORD_W-1:0]  x_low,
    input  logic signed [drmt_pkg::COORD_W-1:0]  y_low,
    input  logic signed [drmt_pkg::COORD_W-1:0]  x_high,
    input  logic signed [drmt_pkg::COORD_W-1:0]  y_high,
    input  logic [drmt_pkg::INDEX_W-1:0]         read_index,
    output logic [drmt_pkg::OUTCOME_W-1:0]       outcome,
    output logic [drmt_pkg::SLOT_W-1:0]          slot,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_x_low,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_y_low,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_x_high,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_y_high,
    output logic [drmt_pkg::COUNT_W-1:0]         entry_count
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > drmt_pkg::INDEX_W) ? CNT_W : drmt_pkg::INDEX_W;
    localparam int RECT_W = 4 * COORD_BITS;

    function automatic logic [drmt_pkg::OUTCOME_W-1:0] kind_outcome(
        input logic [drmt_pkg::KIND_W-1:0] kind
    );
        logic [drmt_pkg::OUTCOME_W-1:0] oc;
        unique case (kind)
            drmt_pkg::K_APPEND:   oc = drmt_pkg::OC_APPENDED;
            drmt_pkg::K_MERGE:    oc = drmt_pkg::OC_MERGED;
            drmt_pkg::K_DROP:     oc = drmt_pkg::OC_DROPPED;
            drmt_pkg::K_READ_OK:  oc = drmt_pkg::OC_READ_OK;
            drmt_pkg::K_CLEAR:    oc = drmt_pkg::OC_CLEARED;
            default:              oc = drmt_pkg::OC_READ_OOR;
        endcase
        return oc;
    endfunction

    // Request registers.
    logic [drmt_pkg::CMD_W-1:0]   item_cmd_reg;
    logic signed [COORD_BITS-1:0] item_xl_reg;
    logic signed [COORD_BITS-1:0] item_yl_reg;
    logic signed [COORD_BITS-1:0] item_xh_reg;
    logic signed [COORD_BITS-1:0] item_yh_reg;
    logic [drmt_pkg::INDEX_W-1:0] item_idx_reg;

    // List and scan state.
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [CNT_W-1:0] scan_addr_reg;
    logic [CNT_W-1:0] scan_addr_next;
    logic             pending_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    // Staged result.
    logic [drmt_pkg::OUTCOME_W-1:0] res_outcome_reg;
    logic [drmt_pkg::SLOT_W-1:0]    res_slot_reg;
    logic [drmt_pkg::SLOT_W-1:0]    res_slot_next;
    logic signed [COORD_BITS-1:0]   res_xl_reg;
    logic signed [COORD_BITS-1:0]   res_yl_reg;
    logic signed [COORD_BITS-1:0]   res_xh_reg;
    logic signed [COORD_BITS-1:0]   res_yh_reg;
    logic signed [COORD_BITS-1:0]   res_xl_next;
    logic signed [COORD_BITS-1:0]   res_yl_next;
    logic signed [COORD_BITS-1:0]   res_xh_next;
    logic signed [COORD_BITS-1:0]   res_yh_next;

    // Output registers.
    logic [drmt_pkg::OUTCOME_W-1:0]     out_outcome_reg;
    logic [drmt_pkg::SLOT_W-1:0]        out_slot_reg;
    logic signed [drmt_pkg::COORD_W-1:0] out_xl_reg;
    logic signed [drmt_pkg::COORD_W-1:0] out_yl_reg;
    logic signed [drmt_pkg::COORD_W-1:0] out_xh_reg;
    logic signed [drmt_pkg::COORD_W-1:0] out_yh_reg;
    logic [drmt_pkg::COUNT_W-1:0]       out_count_reg;

    // Store access.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [RECT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [RECT_W-1:0] ram_rdata;

    logic signed [COORD_BITS-1:0] e_xl;
    logic signed [COORD_BITS-1:0] e_yl;
    logic signed [COORD_BITS-1:0] e_xh;
    logic signed [COORD_BITS-1:0] e_yh;
    logic signed [COORD_BITS-1:0] m_xl;
    logic signed [COORD_BITS-1:0] m_yl;
    logic signed [COORD_BITS-1:0] m_xh;
    logic signed [COORD_BITS-1:0] m_yh;
    logic                         overlap;
    logic                         is_merge;

    drmt_ram #(
        .WIDTH (RECT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign e_xl = ram_rdata[4*COORD_BITS-1 -: COORD_BITS];
    assign e_yl = ram_rdata[3*COORD_BITS-1 -: COORD_BITS];
    assign e_xh = ram_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign e_yh = ram_rdata[COORD_BITS-1 -: COORD_BITS];

    // Edges are inclusive, so touching rectangles count as overlapping.
    assign overlap = !(e_xl > item_xh_reg || e_xh < item_xl_reg ||
                       e_yl > item_yh_reg || e_yh < item_yl_reg);

    assign m_xl = (item_xl_reg < e_xl) ? item_xl_reg : e_xl;
    assign m_yl = (item_yl_reg < e_yl) ? item_yl_reg : e_yl;
    assign m_xh = (item_xh_reg > e_xh) ? item_xh_reg : e_xh;
    assign m_yh = (item_yh_reg > e_yh) ? item_yh_reg : e_yh;

    assign is_merge  = (ctl.kind == drmt_pkg::K_MERGE);
    assign ram_we    = ctl.stage && (is_merge || ctl.kind == drmt_pkg::K_APPEND);
    assign ram_waddr = is_merge ? cmp_idx_reg : total_reg[IDX_W-1:0];
    assign ram_wdata = is_merge ? {m_xl, m_yl, m_xh, m_yh}
                                : {item_xl_reg, item_yl_reg, item_xh_reg, item_yh_reg};
    assign ram_re    = ctl.scan_issue || ctl.read_issue;
    assign ram_raddr = ctl.read_issue ? IDX_W'(item_idx_reg) : scan_addr_reg[IDX_W-1:0];

    assign stat.cmd       = item_cmd_reg;
    assign stat.full      = (total_reg == CNT_W'(MAX_ENTRIES));
    assign stat.empty     = (total_reg == '0);
    assign stat.in_range  = (CMP_W'(item_idx_reg) < CMP_W'(total_reg));
    assign stat.scan_more = (scan_addr_reg < total_reg);
    assign stat.pending   = pending_reg;
    assign stat.hit       = pending_reg && overlap;

    always_comb
    begin
        priority if (ctl.stage && ctl.kind == drmt_pkg::K_CLEAR)
        begin
            total_next = '0;
        end
        else if (ctl.stage && ctl.kind == drmt_pkg::K_APPEND)
        begin
            total_next = total_reg + CNT_W'(1);
        end
        else
        begin
            total_next = total_reg;
        end
    end

    always_comb
    begin
        priority if (ctl.scan_start)
        begin
            scan_addr_next = '0;
        end
        else if (ctl.scan_issue)
        begin
            scan_addr_next = scan_addr_reg + CNT_W'(1);
        end
        else
        begin
            scan_addr_next = scan_addr_reg;
        end
    end

    always_comb
    begin
        unique case (ctl.kind)
            drmt_pkg::K_APPEND:
            begin
                res_slot_next = drmt_pkg::SLOT_W'(total_reg);
                res_xl_next   = item_xl_reg;
                res_yl_next   = item_yl_reg;
                res_xh_next   = item_xh_reg;
                res_yh_next   = item_yh_reg;
            end
            drmt_pkg::K_MERGE:
            begin
                res_slot_next = drmt_pkg::SLOT_W'(cmp_idx_reg);
                res_xl_next   = m_xl;
                res_yl_next   = m_yl;
                res_xh_next   = m_xh;
                res_yh_next   = m_yh;
            end
            drmt_pkg::K_DROP:
            begin
                res_slot_next = '0;
                res_xl_next   = item_xl_reg;
                res_yl_next   = item_yl_reg;
                res_xh_next   = item_xh_reg;
                res_yh_next   = item_yh_reg;
            end
            drmt_pkg::K_READ_OK:
            begin
                res_slot_next = item_idx_reg;
                res_xl_next   = e_xl;
                res_yl_next   = e_yl;
                res_xh_next   = e_xh;
                res_yh_next   = e_yh;
            end
            drmt_pkg::K_READ_OOR:
            begin
                res_slot_next = item_idx_reg;
                res_xl_next   = '0;
                res_yl_next   = '0;
                res_xh_next   = '0;
                res_yh_next   = '0;
            end
            default:
            begin
                res_slot_next = '0;
                res_xl_next   = '0;
                res_yl_next   = '0;
                res_xh_next   = '0;
                res_yh_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            scan_addr_reg <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            scan_addr_reg <= scan_addr_next;
            pending_reg   <= ctl.scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_cmd_reg <= command;
            item_xl_reg  <= x_low[COORD_BITS-1:0];
            item_yl_reg  <= y_low[COORD_BITS-1:0];
            item_xh_reg  <= x_high[COORD_BITS-1:0];
            item_yh_reg  <= y_high[COORD_BITS-1:0];
            item_idx_reg <= read_index;
        end
        if (ctl.scan_issue)
        begin
            cmp_idx_reg <= scan_addr_reg[IDX_W-1:0];
        end
        if (ctl.stage)
        begin
            res_outcome_reg <= kind_outcome(ctl.kind);
            res_slot_reg    <= res_slot_next;
            res_xl_reg      <= res_xl_next;
            res_yl_reg      <= res_yl_next;
            res_xh_reg      <= res_xh_next;
            res_yh_reg      <= res_yh_next;
        end
        if (ctl.emit)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_slot_reg    <= res_slot_reg;
            out_xl_reg      <= drmt_pkg::COORD_W'(res_xl_reg);
            out_yl_reg      <= drmt_pkg::COORD_W'(res_yl_reg);
            out_xh_reg      <= drmt_pkg::COORD_W'(res_xh_reg);
            out_yh_reg      <= drmt_pkg::COORD_W'(res_yh_reg);
            out_count_reg   <= drmt_pkg::COUNT_W'(total_reg);
        end
    end

    assign outcome     = out_outcome_reg;
    assign slot        = out_slot_reg;
    assign out_x_low   = out_xl_reg;
    assign out_y_low   = out_yl_reg;
    assign out_x_high  = out_xh_reg;
    assign out_y_high  = out_yh_reg;
    assign entry_count = out_count_reg;

endmodule

FILE: design/drmt_ctrl.sv
// Controller state machine: request decode, store scan sequencing and result hand-off.
module drmt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  drmt_pkg::stat_t stat,
    output drmt_pkg::ctl_t  ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                ctl.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    drmt_pkg::CMD_ADD:
                    begin
                        priority if (stat.full)
                        begin
                            ctl.stage  = 1'b1;
                            ctl.kind   = drmt_pkg::K_DROP;
                            state_next = S_EMIT;
                        end
                        else if (stat.empty)
                        begin
                            ctl.stage  = 1'b1;
                            ctl.kind   = drmt_pkg::K_APPEND;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    drmt_pkg::CMD_READ:
                    begin
                        if (stat.in_range)
                        begin
                            ctl.read_issue = 1'b1;
                            state_next     = S_RDWAIT;
                        end
                        else
                        begin
                            ctl.stage  = 1'b1;
                            ctl.kind   = drmt_pkg::K_READ_OOR;
                            state_next = S_EMIT;
                        end
                    end
                    drmt_pkg::CMD_CLEAR:
                    begin
                        ctl.stage  = 1'b1;
                        ctl.kind   = drmt_pkg::K_CLEAR;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        ctl.stage  = 1'b1;
                        ctl.kind   = drmt_pkg::K_BAD_CMD;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SCAN:
            begin
                // One entry is read per cycle; its compare comes in the cycle after the read.
                priority if (stat.hit)
                begin
                    ctl.stage  = 1'b1;
                    ctl.kind   = drmt_pkg::K_MERGE;
                    state_next = S_EMIT;
                end
                else if (stat.scan_more)
                begin
                    ctl.scan_issue = 1'b1;
                end
                else if (!stat.pending)
                begin
                    ctl.stage  = 1'b1;
                    ctl.kind   = drmt_pkg::K_APPEND;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_RDWAIT:
            begin
                ctl.stage  = 1'b1;
                ctl.kind   = drmt_pkg::K_READ_OK;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/dirty_rect_merge_tracker_top.sv
// Top level of the dirty rectangle list tracker.
// Keeps up to MAX_ENTRIES dirty rectangles in a store with one write and one read port and
// handles one request at a time. A clear, an unused command, an add to a full or empty list
// or an out-of-range read is settled at decode; an in-range read first reads its entry from
// the store; an add to a list that is neither full nor empty scans the store, which delivers
// one entry per cycle, and stops at the first overlapping entry to merge, or appends after
// the last. The result sits in an output register, so the next request is accepted while it
// waits to be taken. The store needs no clearing after reset.
module dirty_rect_merge_tracker_top #(
    parameter int MAX_ENTRIES = drmt_pkg::MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = drmt_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [drmt_pkg::CMD_W-1:0]           command,
    input  logic signed [drmt_pkg::COORD_W-1:0]  x_low,
    input  logic signed [drmt_pkg::COORD_W-1:0]  y_low,
    input  logic signed [drmt_pkg::COORD_W-1:0]  x_high,
    input  logic signed [drmt_pkg::COORD_W-1:0]  y_high,
    input  logic [drmt_pkg::INDEX_W-1:0]         read_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [drmt_pkg::OUTCOME_W-1:0]       outcome,
    output logic [drmt_pkg::SLOT_W-1:0]          slot,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_x_low,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_y_low,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_x_high,
    output logic signed [drmt_pkg::COORD_W-1:0]  out_y_high,
    output logic [drmt_pkg::COUNT_W-1:0]         entry_count
);

    drmt_pkg::ctl_t  ctl;
    drmt_pkg::stat_t stat;

    drmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    drmt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .x_low       (x_low),
        .y_low       (y_low),
        .x_high      (x_high),
        .y_high      (y_high),
        .read_index  (read_index),
        .outcome     (outcome),
        .slot        (slot),
        .out_x_low   (out_x_low),
        .out_y_low   (out_y_low),
        .out_x_high  (out_x_high),
        .out_y_high  (out_y_high),
        .entry_count (entry_count)
    );

    // A request just taken keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous one still in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == drmt_pkg::OC_CLEARED) |-> (entry_count == '0))
        else $error("clear result reports a non-empty list");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == drmt_pkg::OC_DROPPED) |-> (slot == '0))
        else $error("dropped result carries a nonzero slot");

    // A slot written or read lies below the entry count reported with it (checked for MAX_ENTRIES <= 512).
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome == drmt_pkg::OC_APPENDED || outcome == drmt_pkg::OC_MERGED ||
                       outcome == drmt_pkg::OC_READ_OK))
        |-> ((MAX_ENTRIES > 512) || ({1'b0, slot} < entry_count)))
        else $error("result slot not below entry count");

endmodule
